// ===== hdl/triangle_circumcircle_and_containment_defines.svh =====
// assertion macros for the triangle circumcircle block
// used by the top level, no other dependencies
`ifndef TRIANGLE_CIRCUMCIRCLE_AND_CONTAINMENT_DEFINES_SVH
`define TRIANGLE_CIRCUMCIRCLE_AND_CONTAINMENT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TCC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// condition must never hold
`define TCC_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

// ===== hdl/tcc_pkg.sv =====
// shared constants and types for the triangle circumcircle block
// no dependencies
`default_nettype none

package tcc_pkg;

	localparam int TCC_CW   = 16;
	localparam int TCC_FB   = 8;
	localparam int TCC_DW   = 36;
	localparam int TCC_NW   = 60;
	localparam int TCC_RW   = 33;
	localparam int TCC_SW   = 2 * TCC_RW;
	localparam int TCC_RMW  = TCC_RW + 2;
	localparam int TCC_CDIV = 3;
	localparam int TCC_LAT  = 6 + TCC_NW + 5 + TCC_RW + 1;

	typedef struct packed {
		logic signed [TCC_CW-1:0] a_x;
		logic signed [TCC_CW-1:0] a_y;
		logic signed [TCC_CW-1:0] b_x;
		logic signed [TCC_CW-1:0] b_y;
		logic signed [TCC_CW-1:0] c_x;
		logic signed [TCC_CW-1:0] c_y;
		logic signed [TCC_CW-1:0] query_x;
		logic signed [TCC_CW-1:0] query_y;
	} tcc_in_t;

	typedef struct packed {
		logic               inside_res;
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic        [31:0] radius;
		logic               degenerate;
		logic               saturated;
	} tcc_out_t;

	typedef struct packed {
		logic [TCC_DW-1:0] rem;
		logic [TCC_NW-1:0] nq;
		logic [TCC_DW-1:0] den;
		logic              neg;
	} tcc_div_t;

	typedef struct packed {
		logic [TCC_RMW-1:0] rem;
		logic [TCC_RW-1:0]  root;
		logic [TCC_SW-1:0]  rest;
	} tcc_sqrt_t;

	typedef struct packed {
		logic                        in_tri;
		logic                        degen;
		logic signed [TCC_CW+TCC_FB-1:0] base_x;
		logic signed [TCC_CW+TCC_FB-1:0] base_y;
	} tcc_side1_t;

	typedef struct packed {
		logic        in_tri;
		logic        degen;
		logic [31:0] cen_x;
		logic [31:0] cen_y;
		logic        csat;
		logic        rover;
	} tcc_side2_t;

endpackage

`default_nettype wire

// ===== hdl/tcc_div_cell.sv =====
// one restoring division cell: one quotient bit per cycle
// depends on tcc_pkg
`default_nettype none

module tcc_div_cell import tcc_pkg::*; (
	input  wire logic     clk,
	input  wire tcc_div_t lane_i,
	output tcc_div_t      lane_o
);

	logic [TCC_DW:0]   t;
	logic              ge;
	logic [TCC_DW-1:0] rem_n;

	always_comb begin
		t     = {lane_i.rem, lane_i.nq[TCC_NW-1]};
		ge    = t >= {1'b0, lane_i.den};
		rem_n = ge ? TCC_DW'(t - {1'b0, lane_i.den}) : t[TCC_DW-1:0];
	end

	always_ff @(posedge clk) begin
		lane_o.rem <= rem_n;
		lane_o.nq  <= {lane_i.nq[TCC_NW-2:0], ge};
		lane_o.den <= lane_i.den;
		lane_o.neg <= lane_i.neg;
	end

endmodule

`default_nettype wire

// ===== hdl/tcc_sqrt_cell.sv =====
// one restoring square root cell: one root bit per cycle
// depends on tcc_pkg
`default_nettype none

module tcc_sqrt_cell import tcc_pkg::*; (
	input  wire logic      clk,
	input  wire tcc_sqrt_t st_i,
	output tcc_sqrt_t      st_o
);

	logic [TCC_RMW+1:0] t;
	logic [TCC_RMW-1:0] trial;
	logic               ge;
	logic [TCC_RMW-1:0] rem_n;

	always_comb begin
		t     = {st_i.rem, st_i.rest[TCC_SW-1:TCC_SW-2]};
		trial = {st_i.root, 2'b01};
		ge    = t >= (TCC_RMW+2)'(trial);
		rem_n = ge ? TCC_RMW'(t - (TCC_RMW+2)'(trial)) : t[TCC_RMW-1:0];
	end

	always_ff @(posedge clk) begin
		st_o.rem  <= rem_n;
		st_o.root <= {st_i.root[TCC_RW-2:0], ge};
		st_o.rest <= {st_i.rest[TCC_SW-3:0], 2'b00};
	end

endmodule

`default_nettype wire

// ===== hdl/triangle_circumcircle_and_containment.sv =====
// top level: triangle containment, circumcenter and circumradius pipeline
// depends on tcc_pkg, tcc_div_cell, tcc_sqrt_cell and the defines header
//
// usage:
//  operands carries three vertices and a query point, 16-bit signed each.
//  a transfer in happens at a rising edge with start high and busy low;
//  busy is always low, so a new triangle may be started every cycle.
//  result carries the containment bit, the circumcenter and circumradius
//  with 8 fraction bits, and the degenerate and saturated flags.
//  done is high for exactly one cycle per result; that cycle's closing
//  edge is the result transfer. the receiver cannot stall the block.
//  from the start transfer to the result transfer a triangle passes through
//  6 setup stages, 60 divider cells (one quotient bit each), 5 stages of
//  offset, saturation and squaring, 33 square root cells, one output reg.
//  throughput is one triangle per cycle; the two divider chains and the
//  root chain each take a new operand every cycle.
//  reset clears all valid bits, so no result appears until new starts.
`default_nettype none
`include "triangle_circumcircle_and_containment_defines.svh"

module triangle_circumcircle_and_containment import tcc_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output logic         busy,
	input  wire tcc_in_t operands,
	output logic         done,
	output tcc_out_t     result
);

	// stage 1
	logic    v_s1;
	tcc_in_t in_s1;

	// stage 2
	logic                    v_s2;
	logic signed [16:0]      ex_s2, ey_s2, fx_s2, fy_s2;
	logic signed [33:0]      p_efy_s2, p_eyfx_s2, p_exx_s2, p_eyy_s2, p_fxx_s2, p_fyy_s2;
	logic signed [33:0]      pp1_s2 [3];
	logic signed [33:0]      pp2_s2 [3];
	logic signed [33:0]      pq1_s2 [3];
	logic signed [33:0]      pq2_s2 [3];
	logic signed [TCC_CW-1:0] ax_s2, ay_s2;
	logic signed [17:0]      sx_s2, sy_s2;

	// stage 3
	logic                    v_s3, inside_s3;
	logic signed [35:0]      d_s3;
	logic signed [34:0]      le_s3, lf_s3;
	logic signed [16:0]      ex_s3, ey_s3, fx_s3, fy_s3;
	logic signed [TCC_CW-1:0] ax_s3, ay_s3;
	logic signed [17:0]      sx_s3, sy_s3;

	// stage 4
	logic                    v_s4, inside_s4, ds_s4, degen_s4;
	logic [TCC_DW-1:0]       dmag_s4;
	logic signed [51:0]      m_lefy_s4, m_lfey_s4, m_lfex_s4, m_lefx_s4;
	logic signed [TCC_CW-1:0] ax_s4, ay_s4;
	logic signed [17:0]      sx_s4, sy_s4;

	// stage 5
	logic                    v_s5, inside_s5, degen_s5;
	logic [TCC_DW-1:0]       dmag_s5, dm1_s5;
	logic signed [52:0]      nnx_s5, nny_s5;
	logic signed [TCC_CW-1:0] ax_s5, ay_s5;
	logic signed [17:0]      sx_s5, sy_s5;

	// stage 6
	logic       v_s6;
	tcc_div_t   divx_s6, divy_s6;
	tcc_side1_t side1_s6;

	// divider chains
	tcc_div_t   divx_d [TCC_NW+1];
	tcc_div_t   divy_d [TCC_NW+1];
	logic       dv_q [TCC_NW];
	tcc_side1_t side1_q [TCC_NW];

	// post divider stages
	logic               v_p1, v_p2, v_p3, v_p4, v_p5;
	tcc_side1_t         side1_p1, side1_p2;
	logic signed [61:0] offx_p1, offy_p1;
	logic signed [61:0] cenx_p2, ceny_p2, roffx_p2, roffy_p2;
	logic               inside_p3, degen_p3, csat_p3;
	logic [31:0]        cenx_p3, ceny_p3;
	logic [61:0]        magx_p3, magy_p3;
	tcc_side2_t         side2_p4, side2_p5;
	logic [63:0]        sqx_p4, sqy_p4;
	tcc_sqrt_t          sq_p5;

	// root chain
	tcc_sqrt_t  sq_d [TCC_RW+1];
	logic       sv_q [TCC_RW];
	tcc_side2_t side2_q [TCC_RW];

	logic     done_q;
	tcc_out_t res_q;

	assign busy = 1'b0;

	// stage 1: capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		in_s1 <= operands;
	end

	// stage 2: edge vectors and products
	logic signed [TCC_CW-1:0] ox [3];
	logic signed [TCC_CW-1:0] oy [3];
	logic signed [TCC_CW-1:0] tx [3];
	logic signed [TCC_CW-1:0] ty [3];
	logic signed [TCC_CW-1:0] qx [3];
	logic signed [TCC_CW-1:0] qy [3];
	logic signed [16:0]       dex [3];
	logic signed [16:0]       dey [3];
	logic signed [16:0]       dpx [3];
	logic signed [16:0]       dpy [3];
	logic signed [16:0]       dqx [3];
	logic signed [16:0]       dqy [3];
	logic signed [16:0]       ex_c, ey_c, fx_c, fy_c;

	always_comb begin
		ox = '{in_s1.b_x, in_s1.a_x, in_s1.a_x};
		oy = '{in_s1.b_y, in_s1.a_y, in_s1.a_y};
		tx = '{in_s1.c_x, in_s1.c_x, in_s1.b_x};
		ty = '{in_s1.c_y, in_s1.c_y, in_s1.b_y};
		qx = '{in_s1.a_x, in_s1.b_x, in_s1.c_x};
		qy = '{in_s1.a_y, in_s1.b_y, in_s1.c_y};
		for (int k = 0; k < 3; k++) begin
			dex[k] = 17'(tx[k]) - 17'(ox[k]);
			dey[k] = 17'(ty[k]) - 17'(oy[k]);
			dpx[k] = 17'(in_s1.query_x) - 17'(ox[k]);
			dpy[k] = 17'(in_s1.query_y) - 17'(oy[k]);
			dqx[k] = 17'(qx[k]) - 17'(ox[k]);
			dqy[k] = 17'(qy[k]) - 17'(oy[k]);
		end
		ex_c = 17'(in_s1.b_x) - 17'(in_s1.a_x);
		ey_c = 17'(in_s1.b_y) - 17'(in_s1.a_y);
		fx_c = 17'(in_s1.c_x) - 17'(in_s1.a_x);
		fy_c = 17'(in_s1.c_y) - 17'(in_s1.a_y);
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			pp1_s2[k] <= dex[k] * dpy[k];
			pp2_s2[k] <= dey[k] * dpx[k];
			pq1_s2[k] <= dex[k] * dqy[k];
			pq2_s2[k] <= dey[k] * dqx[k];
		end
		ex_s2     <= ex_c;
		ey_s2     <= ey_c;
		fx_s2     <= fx_c;
		fy_s2     <= fy_c;
		p_efy_s2  <= ex_c * fy_c;
		p_eyfx_s2 <= ey_c * fx_c;
		p_exx_s2  <= ex_c * ex_c;
		p_eyy_s2  <= ey_c * ey_c;
		p_fxx_s2  <= fx_c * fx_c;
		p_fyy_s2  <= fy_c * fy_c;
		ax_s2     <= in_s1.a_x;
		ay_s2     <= in_s1.a_y;
		sx_s2     <= 18'(in_s1.a_x) + 18'(in_s1.b_x) + 18'(in_s1.c_x);
		sy_s2     <= 18'(in_s1.a_y) + 18'(in_s1.b_y) + 18'(in_s1.c_y);
	end

	// stage 3: determinant, squared lengths, containment
	logic signed [34:0] c1 [3];
	logic signed [34:0] c2 [3];
	logic [2:0]         same;
	logic signed [34:0] det_c;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			c1[k]   = 35'(pp1_s2[k]) - 35'(pp2_s2[k]);
			c2[k]   = 35'(pq1_s2[k]) - 35'(pq2_s2[k]);
			same[k] = (~c1[k][34] & ~c2[k][34]) |
			          ((c1[k][34] | (c1[k] == '0)) & (c2[k][34] | (c2[k] == '0)));
		end
		det_c = 35'(p_efy_s2) - 35'(p_eyfx_s2);
	end

	always_ff @(posedge clk) begin
		inside_s3 <= &same;
		d_s3      <= {det_c, 1'b0};
		le_s3     <= 35'(p_exx_s2) + 35'(p_eyy_s2);
		lf_s3     <= 35'(p_fxx_s2) + 35'(p_fyy_s2);
		ex_s3     <= ex_s2;
		ey_s3     <= ey_s2;
		fx_s3     <= fx_s2;
		fy_s3     <= fy_s2;
		ax_s3     <= ax_s2;
		ay_s3     <= ay_s2;
		sx_s3     <= sx_s2;
		sy_s3     <= sy_s2;
	end

	// stage 4: numerator products, divisor magnitude
	always_ff @(posedge clk) begin
		m_lefy_s4 <= le_s3 * fy_s3;
		m_lfey_s4 <= lf_s3 * ey_s3;
		m_lfex_s4 <= lf_s3 * ex_s3;
		m_lefx_s4 <= le_s3 * fx_s3;
		ds_s4     <= d_s3[35];
		dmag_s4   <= d_s3[35] ? TCC_DW'(-d_s3) : TCC_DW'(d_s3);
		degen_s4  <= d_s3 == '0;
		inside_s4 <= inside_s3;
		ax_s4     <= ax_s3;
		ay_s4     <= ay_s3;
		sx_s4     <= sx_s3;
		sy_s4     <= sy_s3;
	end

	// stage 5: numerators, sign folded from the divisor
	always_ff @(posedge clk) begin
		nnx_s5    <= ds_s4 ? 53'(m_lfey_s4) - 53'(m_lefy_s4)
		                   : 53'(m_lefy_s4) - 53'(m_lfey_s4);
		nny_s5    <= ds_s4 ? 53'(m_lefx_s4) - 53'(m_lfex_s4)
		                   : 53'(m_lfex_s4) - 53'(m_lefx_s4);
		dmag_s5   <= dmag_s4;
		dm1_s5    <= dmag_s4 - TCC_DW'(1);
		degen_s5  <= degen_s4;
		inside_s5 <= inside_s4;
		ax_s5     <= ax_s4;
		ay_s5     <= ay_s4;
		sx_s5     <= sx_s4;
		sy_s5     <= sy_s4;
	end

	// stage 6: divider operands (floor or centroid truncation)
	logic signed [52+TCC_FB:0]    nshx, nshy;
	logic [52+TCC_FB:0]           tnx, tny;
	logic signed [17+TCC_FB:0]    gshx, gshy;
	logic [17+TCC_FB:0]           gmx, gmy;
	tcc_div_t                     divx_c, divy_c;

	always_comb begin
		nshx = $signed({nnx_s5, {TCC_FB{1'b0}}});
		nshy = $signed({nny_s5, {TCC_FB{1'b0}}});
		tnx  = nshx[52+TCC_FB] ? (53+TCC_FB)'(dm1_s5) - nshx : nshx;
		tny  = nshy[52+TCC_FB] ? (53+TCC_FB)'(dm1_s5) - nshy : nshy;
		gshx = $signed({sx_s5, {TCC_FB{1'b0}}});
		gshy = $signed({sy_s5, {TCC_FB{1'b0}}});
		gmx  = sx_s5[17] ? (18+TCC_FB)'(-gshx) : gshx;
		gmy  = sy_s5[17] ? (18+TCC_FB)'(-gshy) : gshy;
		divx_c.rem = '0;
		divy_c.rem = '0;
		if (degen_s5) begin
			divx_c.nq  = TCC_NW'(gmx);
			divy_c.nq  = TCC_NW'(gmy);
			divx_c.den = TCC_DW'(TCC_CDIV);
			divy_c.den = TCC_DW'(TCC_CDIV);
			divx_c.neg = sx_s5[17];
			divy_c.neg = sy_s5[17];
		end else begin
			divx_c.nq  = tnx[TCC_NW-1:0];
			divy_c.nq  = tny[TCC_NW-1:0];
			divx_c.den = dmag_s5;
			divy_c.den = dmag_s5;
			divx_c.neg = nshx[52+TCC_FB];
			divy_c.neg = nshy[52+TCC_FB];
		end
	end

	always_ff @(posedge clk) begin
		divx_s6         <= divx_c;
		divy_s6         <= divy_c;
		side1_s6.in_tri <= inside_s5;
		side1_s6.degen  <= degen_s5;
		side1_s6.base_x <= $signed({ax_s5, {TCC_FB{1'b0}}});
		side1_s6.base_y <= $signed({ay_s5, {TCC_FB{1'b0}}});
	end

	// divider chains
	assign divx_d[0] = divx_s6;
	assign divy_d[0] = divy_s6;

	for (genvar k = 0; k < TCC_NW; k++) begin : g_div
		tcc_div_cell u_cell_x (.clk(clk), .lane_i(divx_d[k]), .lane_o(divx_d[k+1]));
		tcc_div_cell u_cell_y (.clk(clk), .lane_i(divy_d[k]), .lane_o(divy_d[k+1]));
	end

	always_ff @(posedge clk) begin
		side1_q[0] <= side1_s6;
		for (int k = 1; k < TCC_NW; k++) begin
			side1_q[k] <= side1_q[k-1];
		end
	end

	// p1: signed quotients
	always_ff @(posedge clk) begin
		offx_p1  <= divx_d[TCC_NW].neg ? -$signed({2'b00, divx_d[TCC_NW].nq})
		                               :  $signed({2'b00, divx_d[TCC_NW].nq});
		offy_p1  <= divy_d[TCC_NW].neg ? -$signed({2'b00, divy_d[TCC_NW].nq})
		                               :  $signed({2'b00, divy_d[TCC_NW].nq});
		side1_p1 <= side1_q[TCC_NW-1];
	end

	// p2: centers and offsets from vertex a
	always_ff @(posedge clk) begin
		cenx_p2  <= side1_p1.degen ? offx_p1 : offx_p1 + 62'(side1_p1.base_x);
		ceny_p2  <= side1_p1.degen ? offy_p1 : offy_p1 + 62'(side1_p1.base_y);
		roffx_p2 <= side1_p1.degen ? offx_p1 - 62'(side1_p1.base_x) : offx_p1;
		roffy_p2 <= side1_p1.degen ? offy_p1 - 62'(side1_p1.base_y) : offy_p1;
		side1_p2 <= side1_p1;
	end

	// p3: clamp centers, offset magnitudes
	logic fitx, fity;

	always_comb begin
		fitx = (&cenx_p2[61:31]) | ~(|cenx_p2[61:31]);
		fity = (&ceny_p2[61:31]) | ~(|ceny_p2[61:31]);
	end

	always_ff @(posedge clk) begin
		cenx_p3   <= fitx ? cenx_p2[31:0] : (cenx_p2[61] ? 32'h8000_0000 : 32'h7FFF_FFFF);
		ceny_p3   <= fity ? ceny_p2[31:0] : (ceny_p2[61] ? 32'h8000_0000 : 32'h7FFF_FFFF);
		csat_p3   <= ~fitx | ~fity;
		magx_p3   <= roffx_p2[61] ? 62'(-roffx_p2) : 62'(roffx_p2);
		magy_p3   <= roffy_p2[61] ? 62'(-roffy_p2) : 62'(roffy_p2);
		inside_p3 <= side1_p2.in_tri;
		degen_p3  <= side1_p2.degen;
	end

	// p4: squares
	always_ff @(posedge clk) begin
		sqx_p4          <= magx_p3[31:0] * magx_p3[31:0];
		sqy_p4          <= magy_p3[31:0] * magy_p3[31:0];
		side2_p4.in_tri <= inside_p3;
		side2_p4.degen  <= degen_p3;
		side2_p4.cen_x  <= cenx_p3;
		side2_p4.cen_y  <= ceny_p3;
		side2_p4.csat   <= csat_p3;
		side2_p4.rover  <= (|magx_p3[61:32]) | (|magy_p3[61:32]);
	end

	// p5: squared distance
	always_ff @(posedge clk) begin
		sq_p5.rem  <= '0;
		sq_p5.root <= '0;
		sq_p5.rest <= TCC_SW'(65'(sqx_p4) + 65'(sqy_p4));
		side2_p5   <= side2_p4;
	end

	// root chain
	assign sq_d[0] = sq_p5;

	for (genvar k = 0; k < TCC_RW; k++) begin : g_sqrt
		tcc_sqrt_cell u_cell (.clk(clk), .st_i(sq_d[k]), .st_o(sq_d[k+1]));
	end

	always_ff @(posedge clk) begin
		side2_q[0] <= side2_p5;
		for (int k = 1; k < TCC_RW; k++) begin
			side2_q[k] <= side2_q[k-1];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
			v_p3 <= 1'b0;
			v_p4 <= 1'b0;
			v_p5 <= 1'b0;
			done_q <= 1'b0;
			for (int k = 0; k < TCC_NW; k++) begin
				dv_q[k] <= 1'b0;
			end
			for (int k = 0; k < TCC_RW; k++) begin
				sv_q[k] <= 1'b0;
			end
		end else begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			dv_q[0] <= v_s6;
			for (int k = 1; k < TCC_NW; k++) begin
				dv_q[k] <= dv_q[k-1];
			end
			v_p1 <= dv_q[TCC_NW-1];
			v_p2 <= v_p1;
			v_p3 <= v_p2;
			v_p4 <= v_p3;
			v_p5 <= v_p4;
			sv_q[0] <= v_p5;
			for (int k = 1; k < TCC_RW; k++) begin
				sv_q[k] <= sv_q[k-1];
			end
			done_q <= sv_q[TCC_RW-1];
		end
	end

	// output register
	logic rsat;

	assign rsat = side2_q[TCC_RW-1].rover | sq_d[TCC_RW].root[TCC_RW-1];

	always_ff @(posedge clk) begin
		res_q.inside_res <= side2_q[TCC_RW-1].in_tri;
		res_q.center_x   <= side2_q[TCC_RW-1].cen_x;
		res_q.center_y   <= side2_q[TCC_RW-1].cen_y;
		res_q.radius     <= rsat ? 32'hFFFF_FFFF : sq_d[TCC_RW].root[31:0];
		res_q.degenerate <= side2_q[TCC_RW-1].degen;
		res_q.saturated  <= side2_q[TCC_RW-1].csat | rsat;
	end

	assign done   = done_q;
	assign result = res_q;

	`TCC_ASSERT_IMP(a_latency, clk, arst_n, done, $past(start, TCC_LAT))
	`TCC_ASSERT_NEVER(a_div_rem, clk, arst_n, dv_q[TCC_NW-1] && ((divx_d[TCC_NW].rem >= divx_d[TCC_NW].den) || (divy_d[TCC_NW].rem >= divy_d[TCC_NW].den)))
	`TCC_ASSERT_IMP(a_sqrt_rem, clk, arst_n, sv_q[TCC_RW-1], sq_d[TCC_RW].rem <= {1'b0, sq_d[TCC_RW].root, 1'b0})

endmodule

`default_nettype wire

// ===== test/tcc_checker.sv =====
// checker for the triangle circumcircle block: watches start and done transfers,
// predicts each result from the accepted operands and compares field by field
// depends on tcc_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcc_checker import tcc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire logic     busy,
	input  wire tcc_in_t  operands,
	input  wire logic     done,
	input  wire tcc_out_t result,
	output int            fail_count,
	output int            pending
);

	tcc_out_t expected_q[$];

	function automatic longint floor_div(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d != 0) && ((n < 0) != (d < 0)))
			q = q - 1;
		return q;
	endfunction

	function automatic logic [31:0] clamp32(longint v, ref logic sat);
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 32'h7fffffff;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic [31:0] root_of(longint dx, longint dy, ref logic sat);
		logic [127:0] s, cand, r;
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		if (dx > 64'sd4294967295 || dy > 64'sd4294967295) begin
			sat = 1'b1;
			return 32'hffffffff;
		end
		s = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
		r = '0;
		for (int b = 33; b >= 0; b--) begin
			cand = r | (128'd1 << b);
			if (cand * cand <= s)
				r = cand;
		end
		if (r > 128'hffffffff) begin
			sat = 1'b1;
			return 32'hffffffff;
		end
		return r[31:0];
	endfunction

	function automatic longint edge_cross(longint ox, longint oy, longint ex, longint ey,
			longint px, longint py);
		return (ex - ox) * (py - oy) - (ey - oy) * (px - ox);
	endfunction

	function automatic logic on_same_side(longint px, longint py, longint qx, longint qy,
			longint ax, longint ay, longint bx, longint by);
		longint c1, c2;
		c1 = edge_cross(ax, ay, bx, by, px, py);
		c2 = edge_cross(ax, ay, bx, by, qx, qy);
		return (c1 >= 0 && c2 >= 0) || (c1 <= 0 && c2 <= 0);
	endfunction

	function automatic tcc_out_t circle_of(tcc_in_t t);
		tcc_out_t o;
		longint ax, ay, bx, by, cx, cy, px, py;
		longint ex, ey, fx, fy, d, le, lf, nx, ny, offx, offy;
		logic sat;
		ax = t.a_x; ay = t.a_y; bx = t.b_x; by = t.b_y;
		cx = t.c_x; cy = t.c_y; px = t.query_x; py = t.query_y;
		ex = bx - ax; ey = by - ay; fx = cx - ax; fy = cy - ay;
		d = 2 * (ex * fy - ey * fx);
		sat = 1'b0;
		o.inside_res = on_same_side(px, py, ax, ay, bx, by, cx, cy) &&
			on_same_side(px, py, bx, by, ax, ay, cx, cy) &&
			on_same_side(px, py, cx, cy, ax, ay, bx, by);
		o.degenerate = (d == 0);
		if (d == 0) begin
			offx = ((ax + bx + cx) * (1 << TCC_FB)) / 3 - ax * (1 << TCC_FB);
			offy = ((ay + by + cy) * (1 << TCC_FB)) / 3 - ay * (1 << TCC_FB);
		end else begin
			le = ex * ex + ey * ey;
			lf = fx * fx + fy * fy;
			nx = le * fy - lf * ey;
			ny = lf * ex - le * fx;
			offx = floor_div(nx <<< TCC_FB, d);
			offy = floor_div(ny <<< TCC_FB, d);
		end
		o.center_x = clamp32(ax * (1 << TCC_FB) + offx, sat);
		o.center_y = clamp32(ay * (1 << TCC_FB) + offy, sat);
		o.radius = root_of(offx, offy, sat);
		o.saturated = sat;
		return o;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		tcc_out_t e;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (start && !busy)
				expected_q.push_back(circle_of(operands));
			if (done) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result with nothing expected, actual %p", $time, result);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_q.pop_front();
					if (e.inside_res !== result.inside_res || e.center_x !== result.center_x ||
							e.center_y !== result.center_y || e.radius !== result.radius ||
							e.degenerate !== result.degenerate ||
							e.saturated !== result.saturated) begin
						$display("%0t: mismatch, expected %p actual %p", $time, e, result);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// testbench top for the triangle circumcircle block: clock, reset, operand stimulus
// and verdict; prediction and comparison live in tcc_checker
// depends on tcc_pkg, tcc_checker and the block itself
`timescale 1ns / 1ps
`default_nettype none

module tb import tcc_pkg::*;;

	logic     clk, arst_n, start, busy, done;
	tcc_in_t  operands;
	tcc_out_t result;
	int       fail_count, pending;
	int       cycles;

	triangle_circumcircle_and_containment dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operands(operands), .done(done), .result(result)
	);

	tcc_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .operands(operands),
		.done(done), .result(result), .fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 300000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic signed [15:0] rand_coord(int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(0, 40)) - 20);
			default: return 16'($signed($urandom_range(0, 2000)) - 1000);
		endcase
	endfunction

	task automatic send_triangle(tcc_in_t t);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
			(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 2));
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start    <= 1'b1;
		operands <= t;
		while (busy) @(negedge clk);
		@(negedge clk);
	endtask

	task automatic send_corners(logic signed [15:0] ax, logic signed [15:0] ay,
			logic signed [15:0] bx, logic signed [15:0] by, logic signed [15:0] cx,
			logic signed [15:0] cy, logic signed [15:0] px, logic signed [15:0] py);
		tcc_in_t t;
		t = '{ax, ay, bx, by, cx, cy, px, py};
		send_triangle(t);
	endtask

	initial begin
		tcc_in_t t;
		int mode, k;
		cycles = 0;
		start = 1'b0;
		operands = '0;
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed corners
		send_corners(0, 0, 10, 0, 0, 10, 2, 2);
		send_corners(0, 0, 10, 0, 0, 10, 20, 20);
		send_corners(0, 0, 10, 0, 0, 10, 5, 5);
		send_corners(0, 0, 10, 0, 0, 10, 0, 0);
		send_corners(0, 0, 10, 0, 0, 10, 5, 0);
		send_corners(0, 0, 0, 10, 10, 0, 1, 1);
		send_corners(0, 0, 0, 0, 0, 0, 0, 0);
		send_corners(1, 1, 1, 1, 1, 1, 1, 2);
		send_corners(0, 0, 5, 5, 10, 10, 3, 3);
		send_corners(-5, -7, 1, 2, 7, 11, -20, 3);
		send_corners(-1, -1, -2, -2, -4, -4, -3, -3);
		send_corners(-32768, -32768, 32767, 32767, 0, 0, 0, 0);
		send_corners(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0);
		send_corners(32767, 32767, -32768, 32767, 32767, -32768, 32767, 32767);
		send_corners(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
		send_corners(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
		send_corners(0, 0, 1, 0, 2, 1, -32768, 32767);
		send_corners(0, 0, 32767, 1, -32768, -1, 0, 0);
		send_corners(-32768, 0, 32767, 1, 32767, 0, 100, 0);
		send_corners(3, 0, 0, 4, 0, 0, 1, 1);
		send_corners(-32768, 32767, 32767, -32768, 0, 1, 0, 0);

		for (int i = 0; i < 800; i++) begin
			mode = $urandom_range(0, 2);
			t.a_x = rand_coord(mode); t.a_y = rand_coord(mode);
			t.b_x = rand_coord(mode); t.b_y = rand_coord(mode);
			t.c_x = rand_coord(mode); t.c_y = rand_coord(mode);
			t.query_x = rand_coord(mode); t.query_y = rand_coord(mode);
			case ($urandom_range(0, 7))
				0: begin
					// collinear vertices
					k = $signed($urandom_range(0, 6)) - 3;
					t.c_x = t.a_x + 16'(k) * (t.b_x - t.a_x);
					t.c_y = t.a_y + 16'(k) * (t.b_y - t.a_y);
				end
				1: begin
					t.query_x = t.b_x;
					t.query_y = t.b_y;
				end
				2: begin
					t.query_x = (t.a_x + t.c_x) / 2;
					t.query_y = (t.a_y + t.c_y) / 2;
				end
				3: begin
					t.query_x = 16'((int'(t.a_x) + t.b_x + t.c_x) / 3);
					t.query_y = 16'((int'(t.a_y) + t.b_y + t.c_y) / 3);
				end
				default: ;
			endcase
			send_triangle(t);
		end
		start <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (TCC_LAT + 20) @(negedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/tcc_pkg.sv
hdl/tcc_div_cell.sv
hdl/tcc_sqrt_cell.sv
hdl/triangle_circumcircle_and_containment.sv
test/tcc_checker.sv
test/tb.sv
